// ===== hdl/multi_motor_cascaded_pid_drive_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-motor cascaded PID drive
// Shared assertion shorthand used by the checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_MOTOR_CASCADED_PID_DRIVE_MACROS_SVH
`define MULTI_MOTOR_CASCADED_PID_DRIVE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define MMPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MMPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpd_pkg
// Types, constants and arithmetic helpers shared by the PID drive modules.
// ----------------------------------------------------------------------------
package mmpd_pkg;

  localparam int MotorsDefault = 8;
  localparam int MotorW        = 3;
  localparam int AddrW         = 5;

  // register indexes
  localparam logic [2:0] RegPosKp    = 3'd0;
  localparam logic [2:0] RegPosKi    = 3'd1;
  localparam logic [2:0] RegPosKd    = 3'd2;
  localparam logic [2:0] RegVelKp    = 3'd3;
  localparam logic [2:0] RegVelKi    = 3'd4;
  localparam logic [2:0] RegVelKd    = 3'd5;
  localparam logic [2:0] RegPwmBound = 3'd6;
  localparam logic [2:0] RegSlewStep = 3'd7;

  localparam logic signed [63:0] SpdLimit = 64'sd4117748;

  // per-motor state word
  typedef struct packed {
    logic signed [47:0] pos_err_sum;
    logic signed [31:0] vel_err_prev;
    logic signed [47:0] vel_err_sum;
    logic signed [31:0] drive_prev;
  } mmpd_state_t;

  // configuration bundle
  typedef struct packed {
    logic signed [31:0] pos_kp;
    logic signed [31:0] pos_ki;
    logic signed [31:0] pos_kd;
    logic signed [31:0] vel_kp;
    logic signed [31:0] vel_ki;
    logic signed [31:0] vel_kd;
    logic [30:0]        pwm_bound;
    logic [30:0]        slew_step;
  } mmpd_cfg_t;

  function automatic logic signed [31:0] tq_p(input logic [2:0] t);
    case (t)
      3'd0, 3'd1, 3'd2: tq_p = 32'sd65536;
      3'd3, 3'd4:       tq_p = 32'sd78643200;
      3'd5, 3'd6:       tq_p = 32'sd131072000;
      default:          tq_p = 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] tq_i(input logic [2:0] t);
    case (t)
      3'd0, 3'd1, 3'd2: tq_i = 32'sd66;
      3'd3, 3'd4:       tq_i = 32'sd65536;
      3'd5, 3'd6:       tq_i = 32'sd655360;
      default:          tq_i = 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] tq_d(input logic [2:0] t);
    case (t)
      3'd0, 3'd1, 3'd2: tq_d = 32'sd262144;
      3'd3, 3'd4:       tq_d = 32'sd2621440;
      3'd5, 3'd6:       tq_d = 32'sd655360;
      default:          tq_d = 32'sd131072;
    endcase
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                              input int bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) sat64 = hi;
    else if (v < lo) sat64 = lo;
    else sat64 = v;
  endfunction

endpackage

// ===== hdl/mmpd_qmul.sv =====
// ----------------------------------------------------------------------------
// mmpd_qmul
// Multicycle Q16.16 multiplier: 32-bit gain times 48-bit operand, result
// divided by 2^16 toward zero. Two 32x24 partial products, one per cycle.
// ----------------------------------------------------------------------------
module mmpd_qmul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] gain,
  input  logic signed [47:0] x,
  output logic               done,
  output logic signed [63:0] prod
);
  import mmpd_pkg::*;

  logic [1:0]  phase;
  logic        neg;
  logic [31:0] ug;
  logic [47:0] ux;
  logic [79:0] acc;
  logic [55:0] pp;
  logic [63:0] mag;

  // partial product of the chosen 24-bit half
  assign pp = {24'd0, ug} * {32'd0, (phase[0] ? ux[23:0] : ux[47:24])};
  assign mag = acc[79:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        2'd0: begin
          if (start) begin
            neg   <= (gain < 0) != (x < 0);
            ug    <= gain[31] ? 32'(-gain) : 32'(gain);
            ux    <= x[47] ? 48'(-x) : 48'(x);
            acc   <= '0;
            phase <= 2'd1;
          end
        end
        2'd1: begin
          acc   <= {24'd0, pp};
          phase <= 2'd2;
        end
        2'd2: begin
          acc   <= acc + {pp, 24'd0};
          phase <= 2'd3;
        end
        default: begin
          prod  <= neg ? -$signed(mag) : $signed(mag);
          done  <= 1'b1;
          phase <= 2'd0;
        end
      endcase
    end
  end
endmodule

// ===== hdl/mmpd_regs.sv =====
// ----------------------------------------------------------------------------
// mmpd_regs
// APB configuration register file for gains, clamp and slew step.
// ----------------------------------------------------------------------------
module mmpd_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mmpd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output mmpd_pkg::mmpd_cfg_t      cfg
);
  import mmpd_pkg::*;

  logic [2:0] idx;
  assign idx = paddr[4:2];

  // write on access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_kp    <= 32'sd196608;
      cfg.pos_ki    <= 32'sd0;
      cfg.pos_kd    <= 32'sd32768;
      cfg.vel_kp    <= 32'sd6554;
      cfg.vel_ki    <= 32'sd0;
      cfg.vel_kd    <= 32'sd19661;
      cfg.pwm_bound <= 31'd6553600;
      cfg.slew_step <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegPosKp:    cfg.pos_kp    <= pwdata;
        RegPosKi:    cfg.pos_ki    <= pwdata;
        RegPosKd:    cfg.pos_kd    <= pwdata;
        RegVelKp:    cfg.vel_kp    <= pwdata;
        RegVelKi:    cfg.vel_ki    <= pwdata;
        RegVelKd:    cfg.vel_kd    <= pwdata;
        RegPwmBound: cfg.pwm_bound <= pwdata[30:0];
        RegSlewStep: cfg.slew_step <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegPosKp:    prdata = cfg.pos_kp;
      RegPosKi:    prdata = cfg.pos_ki;
      RegPosKd:    prdata = cfg.pos_kd;
      RegVelKp:    prdata = cfg.vel_kp;
      RegVelKi:    prdata = cfg.vel_ki;
      RegVelKd:    prdata = cfg.vel_kd;
      RegPwmBound: prdata = {1'b0, cfg.pwm_bound};
      RegSlewStep: prdata = {1'b0, cfg.slew_step};
      default:     prdata = '0;
    endcase
  end
endmodule

// ===== hdl/mmpd_core.sv =====
// ----------------------------------------------------------------------------
// mmpd_core
// Sequencer: reads the motor state word, runs the selected law through the
// shared multiplier and writes the state back (a motor index out of range gives a zero drive).
// ----------------------------------------------------------------------------
module mmpd_core #(
  parameter int MOTORS = mmpd_pkg::MotorsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  mmpd_pkg::mmpd_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                act,
  input  logic [2:0]          motor,
  input  logic signed [31:0]  target_pos,
  input  logic signed [31:0]  meas_pos,
  input  logic signed [31:0]  meas_speed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          motor_out,
  output logic signed [31:0]  drive
);
  import mmpd_pkg::*;

  localparam int IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_MID   = 8'b00010000,
    S_FIN   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_CLR   = 8'b10000000
  } st_t;

  st_t st;
  mmpd_state_t mem [MOTORS];
  mmpd_state_t rd;
  logic [IdxW-1:0] clr_idx;
  logic [IdxW-1:0] rd_idx;

  logic        r_act;
  logic [2:0]  r_motor;
  logic        r_valid_m;
  logic signed [31:0] e, spd, ve;
  logic signed [32:0] dv;
  logic signed [47:0] isum, vsum;
  logic signed [63:0] acc;
  logic [1:0]  term;
  logic        phase2;

  logic               mstart, mdone;
  logic signed [31:0] mgain;
  logic signed [47:0] mx;
  logic signed [63:0] mprod;

  mmpd_qmul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .gain(mgain), .x(mx),
    .done(mdone), .prod(mprod)
  );

  assign in_ready = (st == S_IDLE);
  assign mstart   = (st == S_MUL);

  // operand select per term
  always_comb begin
    mgain = '0;
    mx    = '0;
    if (!r_act) begin
      case (term)
        2'd0:    begin mgain = tq_p(r_motor); mx = 48'(e);   end
        2'd1:    begin mgain = tq_d(r_motor); mx = 48'(spd); end
        default: begin mgain = tq_i(r_motor); mx = isum;     end
      endcase
    end else if (!phase2) begin
      case (term)
        2'd0:    begin mgain = cfg.pos_kp; mx = 48'(e);   end
        2'd1:    begin mgain = cfg.pos_kd; mx = 48'(spd); end
        default: begin mgain = cfg.pos_ki; mx = isum;     end
      endcase
    end else begin
      case (term)
        2'd0:    begin mgain = cfg.vel_kp; mx = 48'(ve);  end
        2'd1:    begin mgain = cfg.vel_kd; mx = 48'(dv);  end
        default: begin mgain = cfg.vel_ki; mx = vsum;     end
      endcase
    end
  end

  // read the incoming motor on acceptance so the word is ready in S_READ
  assign rd_idx = (st == S_IDLE) ? IdxW'(motor) : IdxW'(r_motor);

  // memory read port
  always_ff @(posedge clk) begin
    rd <= mem[rd_idx];
  end

  logic signed [63:0] demand, u, pb, ss, prev, diff, nd;
  always_comb begin
    demand = acc;
    if (demand > SpdLimit) demand = SpdLimit;
    if (demand < -SpdLimit) demand = -SpdLimit;
    pb = 64'($unsigned(cfg.pwm_bound));
    ss = 64'($unsigned(cfg.slew_step));
    u  = acc;
    if (u > pb) u = pb;
    if (u < -pb) u = -pb;
    prev = 64'(rd.drive_prev);
    diff = u - prev;
    if (diff > ss) nd = prev + ss;
    else if (diff < -ss) nd = prev - ss;
    else nd = u;
    nd = sat64(nd, 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (st)
        // sweep state memory to zero after reset
        S_CLR: begin
          mem[clr_idx] <= '0;
          if (32'(clr_idx) == MOTORS - 1) st <= S_IDLE;
          else clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            r_act     <= act;
            r_motor   <= motor;
            r_valid_m <= (32'(motor) < MOTORS);
            e   <= 32'(sat64(64'(target_pos) - 64'(meas_pos), 32));
            spd <= meas_speed;
            st  <= S_READ;
          end
        end
        S_READ: begin
          if (!r_valid_m) begin
            drive     <= '0;
            motor_out <= r_motor;
            out_valid <= 1'b1;
            st        <= S_OUT;
          end else begin
            isum   <= 48'(sat64(64'(rd.pos_err_sum) + 64'(e), 48));
            acc    <= '0;
            term   <= 2'd0;
            phase2 <= 1'b0;
            st     <= S_MUL;
          end
        end
        S_MUL: st <= S_WAIT;
        S_WAIT: begin
          if (mdone) begin
            acc <= acc + mprod;
            if (term == 2'd2) st <= (r_act && !phase2) ? S_MID : S_FIN;
            else begin
              term <= term + 2'd1;
              st   <= S_MUL;
            end
          end
        end
        // inner loop operands from the speed demand
        S_MID: begin
          ve     <= 32'(sat64(demand - 64'(spd), 32));
          dv     <= 33'(sat64(demand - 64'(spd), 32)) - 33'(rd.vel_err_prev);
          vsum   <= 48'(sat64(64'(rd.vel_err_sum)
                    + sat64(demand - 64'(spd), 32), 48));
          acc    <= '0;
          term   <= 2'd0;
          phase2 <= 1'b1;
          st     <= S_MUL;
        end
        S_FIN: begin
          motor_out <= r_motor;
          out_valid <= 1'b1;
          if (!r_act) begin
            drive <= 32'(sat64(acc, 32));
            mem[IdxW'(r_motor)] <= '{pos_err_sum: isum,
              vel_err_prev: rd.vel_err_prev, vel_err_sum: rd.vel_err_sum,
              drive_prev: rd.drive_prev};
          end else begin
            drive <= 32'(nd);
            mem[IdxW'(r_motor)] <= '{pos_err_sum: isum, vel_err_prev: ve,
              vel_err_sum: vsum, drive_prev: 32'(nd)};
          end
          st <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/multi_motor_cascaded_pid_drive.sv =====
// One item at a time: a new item is accepted only after the result of the last
// one has been taken. The state word is read as the transaction is accepted,
// then three (torque law) or six (cascaded law) products go through one
// shared multiplier, then the word is written back; the result is held until
// taken. A motor index out of range gives a zero drive with no products and
// no write-back. After reset a sweep zeroes the state memory of every motor
// before the first item is accepted.
// ----------------------------------------------------------------------------
// multi_motor_cascaded_pid_drive
// Time-shared torque / cascaded position-velocity PID for up to MOTORS motors.
// ----------------------------------------------------------------------------
module multi_motor_cascaded_pid_drive #(
  parameter int MOTORS = mmpd_pkg::MotorsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [103:0]              s_tdata,  // motor, target_pos, meas_pos, meas_speed
  input  logic                      s_tuser,  // action
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,  // motor_out, drive
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mmpd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mmpd_pkg::*;

  mmpd_cfg_t cfg;
  logic [2:0] motor_out;
  logic signed [31:0] drive;

  assign pready  = 1'b1;
  assign m_tdata = {5'd0, drive, motor_out};

  mmpd_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  mmpd_core #(.MOTORS(MOTORS)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready), .act(s_tuser),
    .motor(s_tdata[2:0]), .target_pos(s_tdata[34:3]),
    .meas_pos(s_tdata[66:35]), .meas_speed(s_tdata[98:67]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .motor_out(motor_out), .drive(drive)
  );
endmodule

// ===== hdl/mmpd_checker.sv =====
// ----------------------------------------------------------------------------
// mmpd_checker
// Port-level checks for the PID drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_motor_cascaded_pid_drive_macros.svh"

module mmpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `MMPD_ASSERT_IMPL(a_one_side, clk, rst, m_tvalid, !s_tready)
  `MMPD_ASSERT_NEXT(a_take_busy, clk, rst, s_tvalid && s_tready, !s_tready)
  `MMPD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `MMPD_ASSERT_IMPL(a_pad, clk, rst, m_tvalid, m_tdata[39:35] == 5'd0)
endmodule

bind multi_motor_cascaded_pid_drive mmpd_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
